@@ src/tat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_pkg
// Types and constants shared by the tracker advertisement table.
// ----------------------------------------------------------------------------
package tat_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W        = 4;
  localparam int ADDR_W        = 48;
  localparam int TS_W          = 32;

  localparam logic [15:0] CO_OFFLINE = 16'h004C;
  localparam logic [15:0] CO_A8      = 16'h00A8;
  localparam logic [15:0] CO_75      = 16'h0075;
  localparam logic [7:0]  OF_TYPE    = 8'h12;
  localparam logic [7:0]  OF_LENGTH  = 8'h19;
  localparam logic [7:0]  LEN_MIN    = 8'd2;
  localparam logic [7:0]  LEN_MIN_OF = 8'd4;

  localparam logic signed [7:0] RSSI_FLOOR = -8'sd127;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_NEW     = 3'd1,
    ST_UPDATED = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_OFFLINE = 2'd0,
    KIND_CO_A8   = 2'd1,
    KIND_CO_75   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    kind_t             kind;
    logic signed [7:0] recent_rssi;
    logic signed [7:0] best_rssi;
    logic [TS_W-1:0]   first_seen;
    logic [TS_W-1:0]   last_seen;
  } entry_t;

  typedef struct packed {
    status_t           status;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic signed [7:0] recent_rssi;
    logic signed [7:0] best_rssi;
    logic [TS_W-1:0]   first_seen;
    logic [TS_W-1:0]   last_seen;
    logic [CNT_W-1:0]  entry_count;
  } result_t;

endpackage

@@ src/tat_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_if
// Valid/ready channels for advertisement requests and table results.
// ----------------------------------------------------------------------------
interface tat_adv_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [47:0]       device_address;
  logic [7:0]        mfg_length;
  logic [15:0]       company_id;
  logic [7:0]        frame_type;
  logic [7:0]        frame_length;
  logic signed [7:0] rssi;
  logic [31:0]       timestamp;

  modport source (
    output valid, mode, device_address, mfg_length, company_id, frame_type,
           frame_length, rssi, timestamp,
    input  ready
  );
  modport sink (
    input  valid, mode, device_address, mfg_length, company_id, frame_type,
           frame_length, rssi, timestamp,
    output ready
  );
endinterface

interface tat_res_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [1:0]        tracker_kind;
  logic [3:0]        slot;
  logic signed [7:0] recent_rssi;
  logic signed [7:0] best_rssi;
  logic [31:0]       first_seen;
  logic [31:0]       last_seen;
  logic [4:0]        entry_count;

  modport source (
    output valid, status, tracker_kind, slot, recent_rssi, best_rssi, first_seen,
           last_seen, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, tracker_kind, slot, recent_rssi, best_rssi, first_seen,
           last_seen, entry_count,
    output ready
  );
endinterface

@@ src/tracker_advert_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_advert_table_core
// Classifies advertisements as tracker kinds and keeps a 16-entry table of
// trackers keyed by device address, with last/peak strength and seen times.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  adv     | in  | mode, device_address, mfg_length, company_id, frame_type,
//          |     | frame_length, rssi, timestamp
//  res     | out | status, tracker_kind, slot, recent_rssi, best_rssi,
//          |     | first_seen, last_seen, entry_count
//
// A clear or non-tracker request is registered as a result at accept and
// moves to the output register from the done state. A tracker request walks
// the table through the single read port of the entry memory, one read per
// cycle, and stops early when an address matches.
// Reset empties the table (count to zero); entry contents are not
// cleared. A result waits in the output register while the next request is
// accepted; a stalled result holds the core in its done state.
// ----------------------------------------------------------------------------
module tracker_advert_table_core (
  input logic       clk,
  input logic       rst,
  tat_adv_if.sink   adv,
  tat_res_if.source res
);
  import tat_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;

  logic [ADDR_W-1:0] key;
  logic signed [7:0] rssi_q;
  logic [TS_W-1:0]   ts_q;
  kind_t             kind_q;

  entry_t            mem [TABLE_ENTRIES];
  entry_t            mem_q;
  entry_t            base, upd;

  result_t           res_q, res_next, out_q;
  logic              out_valid;

  logic              accept, cls_hit, issue_ok, hit, miss, full;
  logic              rd_en, mem_we, load_out;
  logic [IDX_W-1:0]  wr_idx;
  kind_t             cls_kind;

  assign accept = adv.valid && adv.ready;

  // classification
  always_comb begin
    cls_hit  = 1'b0;
    cls_kind = KIND_OFFLINE;
    if (adv.mfg_length >= LEN_MIN) begin
      case (adv.company_id)
        CO_OFFLINE: begin
          if (adv.mfg_length >= LEN_MIN_OF && adv.frame_type == OF_TYPE &&
              adv.frame_length == OF_LENGTH) begin
            cls_hit = 1'b1;
          end
        end
        CO_A8: begin
          cls_hit  = 1'b1;
          cls_kind = KIND_CO_A8;
        end
        CO_75: begin
          cls_hit  = 1'b1;
          cls_kind = KIND_CO_75;
        end
        default: cls_hit = 1'b0;
      endcase
    end
  end

  // scan compare, one entry per cycle behind the read
  assign issue_ok = rd_idx < count;
  assign hit      = pend && (mem_q.address == key);
  assign miss     = !pend && !issue_ok;
  assign full     = count == CNT_W'(TABLE_ENTRIES);

  always_comb begin
    if (hit) begin
      base = mem_q;
    end else begin
      base.address     = key;
      base.kind        = kind_q;
      base.recent_rssi = RSSI_FLOOR;
      base.best_rssi   = RSSI_FLOOR;
      base.first_seen  = ts_q;
      base.last_seen   = ts_q;
    end
    upd             = base;
    upd.recent_rssi = rssi_q;
    if (rssi_q > base.best_rssi) begin
      upd.best_rssi = rssi_q;
    end
    upd.last_seen = ts_q;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (adv.mode || !cls_hit) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || miss) state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    adv.ready = state == S_IDLE;
    rd_en     = (state == S_SCAN) && issue_ok;
    mem_we    = (state == S_SCAN) && (hit || (miss && !full));
    wr_idx    = hit ? pend_idx : count[IDX_W-1:0];
    load_out  = (state == S_DONE) && (!out_valid || res.ready);
  end

  // result for the request being finished
  always_comb begin
    res_next = '0;
    if (state == S_IDLE) begin
      if (adv.mode) begin
        res_next.status = ST_CLEARED;
      end else begin
        res_next.status      = ST_NONE;
        res_next.entry_count = count;
      end
    end else if (hit || !full) begin
      res_next.status      = hit ? ST_UPDATED : ST_NEW;
      res_next.kind        = kind_q;
      res_next.slot        = SLOT_W'(wr_idx);
      res_next.recent_rssi = upd.recent_rssi;
      res_next.best_rssi   = upd.best_rssi;
      res_next.first_seen  = upd.first_seen;
      res_next.last_seen   = upd.last_seen;
      res_next.entry_count = hit ? count : count + 1'b1;
    end else begin
      res_next.status      = ST_FULL;
      res_next.kind        = kind_q;
      res_next.entry_count = count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx] <= upd;
    if (rd_en) mem_q <= mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && adv.mode) begin
        count <= '0;
      end else if (state == S_SCAN && miss && !full) begin
        count <= count + 1'b1;
      end
      pend <= accept ? 1'b0 : rd_en;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key    <= adv.device_address;
      rssi_q <= adv.rssi;
      ts_q   <= adv.timestamp;
      kind_q <= cls_kind;
      rd_idx <= '0;
      res_q  <= res_next;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (rd_en) pend_idx <= rd_idx[IDX_W-1:0];
    if (state == S_SCAN && (hit || miss)) res_q <= res_next;
    if (load_out) out_q <= res_q;
  end

  assign res.valid        = out_valid;
  assign res.status       = out_q.status;
  assign res.tracker_kind = out_q.kind;
  assign res.slot         = out_q.slot;
  assign res.recent_rssi  = out_q.recent_rssi;
  assign res.best_rssi    = out_q.best_rssi;
  assign res.first_seen   = out_q.first_seen;
  assign res.last_seen    = out_q.last_seen;
  assign res.entry_count  = out_q.entry_count;

endmodule
